/* design/matrix_arithmetic_engine_macros.svh */
// Assertion macros shared by the matrix arithmetic engine RTL.
// Expects i_clk and i_rst_n in the scope of the including module.
`ifndef MATRIX_ARITHMETIC_ENGINE_MACROS_SVH
`define MATRIX_ARITHMETIC_ENGINE_MACROS_SVH

// Same-cycle implication, off during reset.
`define MAE_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define MAE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mae_pkg.sv */
// Shared types, codes and helpers for the matrix arithmetic engine.
// No dependencies; used by every other file of the block except the macros header.
package mae_pkg;

    localparam int MAX_DIM_DEF   = 16;
    localparam int FRAC_BITS_DEF = 12;

    localparam int DATA_W  = 16;
    localparam int DIM_W   = 5;
    localparam int IDX_W   = 4;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_MUL = 2'd0,
        MODE_ADD = 2'd1,
        MODE_SUB = 2'd2,
        MODE_TRN = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_OP_MODE = 3'd0,
        REG_A_ROWS  = 3'd1,
        REG_A_COLS  = 3'd2,
        REG_B_ROWS  = 3'd3,
        REG_B_COLS  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic clr;
        logic op_vld;
        logic rnd;
    } t_mac_ctl;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d,
                                                 input int max_dim);
        return (int'(d) > max_dim) ? DIM_W'(max_dim) : d;
    endfunction

endpackage

/* design/mae_store.sv */
// One matrix store: single write port, single registered read port.
// Depends on mae_pkg for the element width.
module mae_store #(
    parameter int DEPTH  = mae_pkg::MAX_DIM_DEF * mae_pkg::MAX_DIM_DEF,
    parameter int ADDR_W = 8
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [ADDR_W-1:0]                i_wr_addr,
    input  logic signed [mae_pkg::DATA_W-1:0] i_wr_data,
    input  logic                             i_re,
    input  logic [ADDR_W-1:0]                i_rd_addr,
    output logic signed [mae_pkg::DATA_W-1:0] o_rd_data
);

    logic signed [mae_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [mae_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/mae_mac.sv */
// Shared multiply-accumulate unit with round-half-up and 16-bit saturation.
// Depends on mae_pkg for the control struct and element width.
module mae_mac #(
    parameter int MAX_DIM   = mae_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mae_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mae_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [mae_pkg::DATA_W-1:0] i_a,
    input  logic signed [mae_pkg::DATA_W-1:0] i_b,
    output logic                              o_pend,
    output logic signed [mae_pkg::DATA_W-1:0] o_sat
);

    localparam int PROD_W = 2 * mae_pkg::DATA_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'((64'(1) << FRAC_BITS) >> 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (mae_pkg::DATA_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_mul_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_rnd;
    logic signed [ACC_W-1:0]  rnd_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
        end else begin
            r_mul_vld <= i_ctl.op_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op_vld) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.rnd) begin
            r_rnd <= rnd_sum >>> FRAC_BITS;
        end
    end

    assign rnd_sum = r_acc + HALF;
    assign o_pend  = r_mul_vld;

    always_comb begin
        if (r_rnd > SAT_HI) begin
            o_sat = mae_pkg::DATA_W'(SAT_HI);
        end else if (r_rnd < SAT_LO) begin
            o_sat = mae_pkg::DATA_W'(SAT_LO);
        end else begin
            o_sat = mae_pkg::DATA_W'(r_rnd);
        end
    end

endmodule

/* design/matrix_arithmetic_engine.sv */
// Top level of the matrix arithmetic engine: APB registers, sequencer, stores.
// Depends on mae_pkg, mae_store, mae_mac and matrix_arithmetic_engine_macros.svh.
//
// A request is taken when start is high and busy is low; each request gives one result
// beat on o_valid for a single cycle, which the receiver cannot hold off. Loads and
// requests that end in an error status or carry no operation answer in the cycle after
// acceptance and leave busy low. Add, subtract and transpose reads do one registered
// store read, then the sum or copy, and register the result. A multiply read takes the
// request and clears the accumulator, then a single multiply-accumulate unit takes one
// product term per cycle from the single read port of each store, followed by pipeline
// drain, rounding and saturation. The stores are not cleared by reset.
`include "matrix_arithmetic_engine_macros.svh"

module matrix_arithmetic_engine #(
    parameter int MAX_DIM   = mae_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mae_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mae_pkg::PADDR_W-1:0]        paddr,
    input  logic [mae_pkg::PDATA_W-1:0]        pwdata,
    output logic [mae_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_req_type,
    input  logic [mae_pkg::IDX_W-1:0]          i_row,
    input  logic [mae_pkg::IDX_W-1:0]          i_col,
    input  logic signed [mae_pkg::DATA_W-1:0]  i_value,
    output logic                               o_valid,
    output logic signed [mae_pkg::DATA_W-1:0]  o_result_value,
    output logic [1:0]                         o_status
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW     = mae_pkg::DIM_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ISSUE  = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_ROUND  = 6'b001000,
        ST_FINISH = 6'b010000,
        ST_ELEM   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]    r_op_mode;
    logic [DW-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;

    logic [DW-1:0]     r_left, n_left;
    logic [ADDR_W-1:0] r_a_addr, n_a_addr;
    logic [ADDR_W-1:0] r_b_addr, n_b_addr;
    logic              r_rd_vld;

    logic                              r_valid, n_valid;
    logic signed [mae_pkg::DATA_W-1:0] r_result, n_result;
    logic [1:0]                        r_status, n_status;

    logic              cfg_we;
    logic [2:0]        cfg_idx;
    logic [DW-1:0]     ar, ac, br, bc;
    logic              accept;
    logic [DW-1:0]     row_w, col_w;
    logic [DW-1:0]     ld_nr, ld_nc;
    logic              ld_ok;
    logic              rd_mis;
    logic [DW-1:0]     rd_nr, rd_nc;
    logic              rd_in;
    logic [ADDR_W-1:0] lin_rc, lin_cr, row_base;
    logic              a_we, b_we, rd_en, issue;
    logic [ADDR_W-1:0] a_rd_addr, b_rd_addr;
    logic signed [mae_pkg::DATA_W-1:0] a_q, b_q;
    logic signed [mae_pkg::DATA_W:0]   elem_sum;
    logic signed [mae_pkg::DATA_W-1:0] elem_res;
    logic signed [mae_pkg::DATA_W-1:0] mac_sat;
    logic              mac_pend;
    mae_pkg::t_mac_ctl mac_ctl;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[mae_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= mae_pkg::MODE_MUL;
            r_a_rows  <= DW'(16);
            r_a_cols  <= DW'(16);
            r_b_rows  <= DW'(16);
            r_b_cols  <= DW'(16);
        end else if (cfg_we) begin
            case (cfg_idx)
                mae_pkg::REG_OP_MODE: r_op_mode <= pwdata[1:0];
                mae_pkg::REG_A_ROWS:  r_a_rows  <= pwdata[DW-1:0];
                mae_pkg::REG_A_COLS:  r_a_cols  <= pwdata[DW-1:0];
                mae_pkg::REG_B_ROWS:  r_b_rows  <= pwdata[DW-1:0];
                mae_pkg::REG_B_COLS:  r_b_cols  <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            mae_pkg::REG_OP_MODE: prdata = mae_pkg::PDATA_W'(r_op_mode);
            mae_pkg::REG_A_ROWS:  prdata = mae_pkg::PDATA_W'(r_a_rows);
            mae_pkg::REG_A_COLS:  prdata = mae_pkg::PDATA_W'(r_a_cols);
            mae_pkg::REG_B_ROWS:  prdata = mae_pkg::PDATA_W'(r_b_rows);
            mae_pkg::REG_B_COLS:  prdata = mae_pkg::PDATA_W'(r_b_cols);
            default:              prdata = '0;
        endcase
    end

    // Request decode
    assign ar = mae_pkg::eff_dim(r_a_rows, MAX_DIM);
    assign ac = mae_pkg::eff_dim(r_a_cols, MAX_DIM);
    assign br = mae_pkg::eff_dim(r_b_rows, MAX_DIM);
    assign bc = mae_pkg::eff_dim(r_b_cols, MAX_DIM);

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign row_w  = DW'(i_row);
    assign col_w  = DW'(i_col);

    assign ld_nr = (i_req_type == mae_pkg::REQ_LOAD_A) ? ar : br;
    assign ld_nc = (i_req_type == mae_pkg::REQ_LOAD_A) ? ac : bc;
    assign ld_ok = (row_w < ld_nr) && (col_w < ld_nc);

    always_comb begin
        case (r_op_mode)
            mae_pkg::MODE_MUL: begin
                rd_mis = (ac != br);
                rd_nr  = ar;
                rd_nc  = bc;
            end
            mae_pkg::MODE_ADD, mae_pkg::MODE_SUB: begin
                rd_mis = (ar != br) || (ac != bc);
                rd_nr  = ar;
                rd_nc  = ac;
            end
            default: begin
                rd_mis = 1'b0;
                rd_nr  = ac;
                rd_nc  = ar;
            end
        endcase
    end

    assign rd_in = (row_w < rd_nr) && (col_w < rd_nc);

    assign lin_rc   = ADDR_W'(int'(i_row) * MAX_DIM + int'(i_col));
    assign lin_cr   = ADDR_W'(int'(i_col) * MAX_DIM + int'(i_row));
    assign row_base = ADDR_W'(int'(i_row) * MAX_DIM);

    // Stores
    assign issue = (r_state == ST_ISSUE);
    assign a_we  = accept && (i_req_type == mae_pkg::REQ_LOAD_A) && ld_ok;
    assign b_we  = accept && (i_req_type == mae_pkg::REQ_LOAD_B) && ld_ok;
    assign rd_en = issue || (accept && (i_req_type == mae_pkg::REQ_READ));

    assign a_rd_addr = issue ? r_a_addr :
                       (r_op_mode == mae_pkg::MODE_TRN) ? lin_cr : lin_rc;
    assign b_rd_addr = issue ? r_b_addr : lin_rc;

    mae_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store_a (
        .i_clk     (i_clk),
        .i_we      (a_we),
        .i_wr_addr (lin_rc),
        .i_wr_data (i_value),
        .i_re      (rd_en),
        .i_rd_addr (a_rd_addr),
        .o_rd_data (a_q)
    );

    mae_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store_b (
        .i_clk     (i_clk),
        .i_we      (b_we),
        .i_wr_addr (lin_rc),
        .i_wr_data (i_value),
        .i_re      (rd_en),
        .i_rd_addr (b_rd_addr),
        .o_rd_data (b_q)
    );

    mae_mac #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (a_q),
        .i_b     (b_q),
        .o_pend  (mac_pend),
        .o_sat   (mac_sat)
    );

    // Element-wise result
    assign elem_sum = (r_op_mode == mae_pkg::MODE_SUB) ?
                      ({a_q[mae_pkg::DATA_W-1], a_q} - {b_q[mae_pkg::DATA_W-1], b_q}) :
                      ({a_q[mae_pkg::DATA_W-1], a_q} + {b_q[mae_pkg::DATA_W-1], b_q});

    always_comb begin
        if (r_op_mode == mae_pkg::MODE_TRN) begin
            elem_res = a_q;
        end else if (elem_sum[mae_pkg::DATA_W] != elem_sum[mae_pkg::DATA_W-1]) begin
            elem_res = elem_sum[mae_pkg::DATA_W] ?
                       {1'b1, {(mae_pkg::DATA_W-1){1'b0}}} :
                       {1'b0, {(mae_pkg::DATA_W-1){1'b1}}};
        end else begin
            elem_res = elem_sum[mae_pkg::DATA_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_left         = r_left;
        n_a_addr       = r_a_addr;
        n_b_addr       = r_b_addr;
        n_valid        = 1'b0;
        n_result       = r_result;
        n_status       = r_status;
        mac_ctl.clr    = 1'b0;
        mac_ctl.op_vld = r_rd_vld;
        mac_ctl.rnd    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        mae_pkg::REQ_LOAD_A, mae_pkg::REQ_LOAD_B: begin
                            n_valid  = 1'b1;
                            n_result = '0;
                            n_status = ld_ok ? mae_pkg::ST_OK : mae_pkg::ST_RANGE;
                        end
                        mae_pkg::REQ_READ: begin
                            if (rd_mis) begin
                                n_valid  = 1'b1;
                                n_result = '0;
                                n_status = mae_pkg::ST_MISMATCH;
                            end else if (!rd_in) begin
                                n_valid  = 1'b1;
                                n_result = '0;
                                n_status = mae_pkg::ST_RANGE;
                            end else if (r_op_mode == mae_pkg::MODE_MUL) begin
                                mac_ctl.clr = 1'b1;
                                n_left      = ac;
                                n_a_addr    = row_base;
                                n_b_addr    = ADDR_W'(i_col);
                                n_state     = (ac == '0) ? ST_DRAIN : ST_ISSUE;
                            end else begin
                                n_state = ST_ELEM;
                            end
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_result = '0;
                            n_status = mae_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                n_left   = r_left - DW'(1);
                n_a_addr = r_a_addr + ADDR_W'(1);
                n_b_addr = r_b_addr + ADDR_W'(MAX_DIM);
                if (r_left == DW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !mac_pend) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                mac_ctl.rnd = 1'b1;
                n_state     = ST_FINISH;
            end
            ST_FINISH: begin
                n_valid  = 1'b1;
                n_result = mac_sat;
                n_status = mae_pkg::ST_OK;
                n_state  = ST_IDLE;
            end
            ST_ELEM: begin
                n_valid  = 1'b1;
                n_result = elem_res;
                n_status = mae_pkg::ST_OK;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_a_addr <= n_a_addr;
        r_b_addr <= n_b_addr;
        r_result <= n_result;
        r_status <= n_status;
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;

    `MAE_ASSERT_HOLD(a_beat_not_busy, o_valid, !busy, "result beat while busy")
    `MAE_ASSERT_NEXT(a_accept_moves, start && !busy, o_valid || busy, "request lost")
    `MAE_ASSERT_HOLD(a_err_zero, o_valid && (o_status != mae_pkg::ST_OK),
                     o_result_value == '0, "error beat carries data")
    `MAE_ASSERT_HOLD(a_issue_count, r_state == ST_ISSUE, r_left != '0,
                     "issue with no terms left")
    `MAE_ASSERT_HOLD(a_round_drained, r_state == ST_ROUND, !r_rd_vld && !mac_pend,
                     "round before drain")

endmodule

/* dv/mae_result_checker.sv */
// Result checker for the matrix arithmetic engine: tracks register writes, predicts
// every accepted request beat and compares each result beat against the oldest due.
// Depends on mae_pkg for widths, request, mode, status and register codes.
module mae_result_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic                               i_pready,
    input  logic [mae_pkg::PADDR_W-1:0]        i_paddr,
    input  logic [mae_pkg::PDATA_W-1:0]        i_pwdata,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic [1:0]                         i_req_type,
    input  logic [mae_pkg::IDX_W-1:0]          i_row,
    input  logic [mae_pkg::IDX_W-1:0]          i_col,
    input  logic signed [mae_pkg::DATA_W-1:0]  i_value,
    input  logic                               i_res_valid,
    input  logic signed [mae_pkg::DATA_W-1:0]  i_res_value,
    input  logic [1:0]                         i_res_status,
    output int                                 o_pending,
    output int                                 o_mismatches
);
    import mae_pkg::*;

    localparam int     DIM_MAX    = MAX_DIM_DEF;
    localparam int     FRAC       = FRAC_BITS_DEF;
    localparam longint ROUND_HALF = longint'(1) << (FRAC - 1);
    localparam longint SAT_HI     = 32767;
    localparam longint SAT_LO     = -32768;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
    } t_element_result;

    logic signed [DATA_W-1:0] a_mem [0:255];
    logic signed [DATA_W-1:0] b_mem [0:255];
    t_mode                    cur_mode = MODE_MUL;
    logic [DIM_W-1:0]         a_rows   = 5'd16;
    logic [DIM_W-1:0]         a_cols   = 5'd16;
    logic [DIM_W-1:0]         b_rows   = 5'd16;
    logic [DIM_W-1:0]         b_cols   = 5'd16;
    t_element_result          results_due [$];
    int                       mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    initial begin
        foreach (a_mem[i]) begin
            a_mem[i] = '0;
            b_mem[i] = '0;
        end
        o_pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int clip_dim(input logic [DIM_W-1:0] d);
        return (d > DIM_MAX) ? DIM_MAX : int'(d);
    endfunction

    function automatic logic signed [DATA_W-1:0] saturate(input longint x);
        if (x > SAT_HI) return 16'sh7FFF;
        if (x < SAT_LO) return 16'sh8000;
        return DATA_W'(x);
    endfunction

    function automatic t_element_result read_element(input logic [IDX_W-1:0] r,
                                                     input logic [IDX_W-1:0] c);
        t_element_result          out;
        int                       ar;
        int                       ac;
        int                       br;
        int                       bc;
        longint                   acc;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        out.value  = '0;
        out.status = ST_OK;
        ar = clip_dim(a_rows);
        ac = clip_dim(a_cols);
        br = clip_dim(b_rows);
        bc = clip_dim(b_cols);
        case (cur_mode)
            MODE_MUL: begin
                if (ac != br) begin
                    out.status = ST_MISMATCH;
                end else if (r >= ar || c >= bc) begin
                    out.status = ST_RANGE;
                end else begin
                    acc = 0;
                    for (int k = 0; k < ac; k++) begin
                        acc += longint'(a_mem[{r, 4'(k)}]) * longint'(b_mem[{4'(k), c}]);
                    end
                    out.value = saturate((acc + ROUND_HALF) >>> FRAC);
                end
            end
            MODE_ADD, MODE_SUB: begin
                if (ar != br || ac != bc) begin
                    out.status = ST_MISMATCH;
                end else if (r >= ar || c >= ac) begin
                    out.status = ST_RANGE;
                end else begin
                    x = a_mem[{r, c}];
                    y = b_mem[{r, c}];
                    out.value = saturate((cur_mode == MODE_ADD) ?
                                         longint'(x) + longint'(y) :
                                         longint'(x) - longint'(y));
                end
            end
            default: begin
                if (r >= ac || c >= ar) out.status = ST_RANGE;
                else out.value = a_mem[{c, r}];
            end
        endcase
        return out;
    endfunction

    function automatic t_element_result predict_element(input t_req rq,
                                                        input logic [IDX_W-1:0] r,
                                                        input logic [IDX_W-1:0] c,
                                                        input logic signed [DATA_W-1:0] v);
        t_element_result out;
        int              nr;
        int              nc;
        out.value  = '0;
        out.status = ST_OK;
        case (rq)
            REQ_LOAD_A, REQ_LOAD_B: begin
                nr = clip_dim((rq == REQ_LOAD_A) ? a_rows : b_rows);
                nc = clip_dim((rq == REQ_LOAD_A) ? a_cols : b_cols);
                if (r >= nr || c >= nc) out.status = ST_RANGE;
                else if (rq == REQ_LOAD_A) a_mem[{r, c}] = v;
                else b_mem[{r, c}] = v;
            end
            REQ_READ: out = read_element(r, c);
            default: ;
        endcase
        return out;
    endfunction

    always @(posedge i_clk) begin
        t_element_result due;
        if (i_rst_n) begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_OP_MODE: cur_mode = t_mode'(i_pwdata[1:0]);
                    REG_A_ROWS:  a_rows   = i_pwdata[DIM_W-1:0];
                    REG_A_COLS:  a_cols   = i_pwdata[DIM_W-1:0];
                    REG_B_ROWS:  b_rows   = i_pwdata[DIM_W-1:0];
                    REG_B_COLS:  b_cols   = i_pwdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing due: value %0d status %0d",
                                              i_res_value, i_res_status));
                end else begin
                    due = results_due.pop_front();
                    if (i_res_value !== due.value)
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  i_res_value, due.value));
                    if (i_res_status !== due.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_res_status, due.status));
                end
            end
            if (i_start && !i_busy)
                results_due = {results_due,
                               predict_element(t_req'(i_req_type), i_row, i_col, i_value)};
        end
        o_pending <= results_due.size();
    end

endmodule

/* dv/matrix_arithmetic_engine_test.sv */
// Testbench top for the matrix arithmetic engine: clock, reset, APB register writes
// and paced request beats; the verdict comes from the mismatch count of mae_result_checker and a stall watchdog.
// Depends on mae_pkg, mae_result_checker and the matrix_arithmetic_engine RTL.
module matrix_arithmetic_engine_test;
    import mae_pkg::*;

    localparam int         N_PHASES       = 12;
    localparam int         PHASE_BEATS    = 120;
    localparam int         SETTLE_CYCLES  = 25;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [2:0] REG_SPARE      = 3'd7;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       start;
    logic                       busy;
    logic [1:0]                 i_req_type;
    logic [IDX_W-1:0]           i_row;
    logic [IDX_W-1:0]           i_col;
    logic signed [DATA_W-1:0]   i_value;
    logic                       o_valid;
    logic signed [DATA_W-1:0]   o_result_value;
    logic [1:0]                 o_status;

    int                         pending;
    int                         mismatches;
    int                         burst_left = 1;
    int                         stall_cycles = 0;
    t_mode                      cfg_mode   = MODE_MUL;
    logic [DIM_W-1:0]           cfg_a_rows = 5'd16;
    logic [DIM_W-1:0]           cfg_a_cols = 5'd16;
    logic [DIM_W-1:0]           cfg_b_rows = 5'd16;
    logic [DIM_W-1:0]           cfg_b_cols = 5'd16;

    always #4 i_clk = ~i_clk;

    matrix_arithmetic_engine u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    mae_result_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_start      (start),
        .i_busy       (busy),
        .i_req_type   (i_req_type),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_value      (i_value),
        .i_res_valid  (o_valid),
        .i_res_value  (o_result_value),
        .i_res_status (o_status),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("** matrix_arithmetic_engine: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int clip_dim(input logic [DIM_W-1:0] d);
        return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(d);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 5'd0 : DIM_W'($urandom_range(17, 31));
            1:       return 5'd16;
            default: return DIM_W'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] fill_value();
        if ($urandom_range(0, 9) == 0) return DATA_W'($urandom);
        return DATA_W'($urandom_range(0, 8191)) - 16'd4096;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_beat(input t_req rq, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
        int gap;
        start      <= 1'b1;
        i_req_type <= rq;
        i_row      <= r;
        i_col      <= c;
        i_value    <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                        $urandom_range(1, 8);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every due beat is back and the block has drained
    task automatic settle();
        if (start) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input t_mode m, input logic [DIM_W-1:0] ar,
                              input logic [DIM_W-1:0] ac, input logic [DIM_W-1:0] br,
                              input logic [DIM_W-1:0] bc);
        logic [PDATA_W-1:0] junk;
        settle();
        junk = $urandom_range(0, 1) ? PDATA_W'($urandom) : '0;
        write_reg(REG_OP_MODE, {junk[PDATA_W-1:2], m});
        write_reg(REG_A_ROWS, {junk[PDATA_W-1:DIM_W], ar});
        write_reg(REG_A_COLS, {junk[PDATA_W-1:DIM_W], ac});
        write_reg(REG_B_ROWS, {junk[PDATA_W-1:DIM_W], br});
        write_reg(REG_B_COLS, {junk[PDATA_W-1:DIM_W], bc});
        cfg_mode   = m;
        cfg_a_rows = ar;
        cfg_a_cols = ac;
        cfg_b_rows = br;
        cfg_b_cols = bc;
    endtask

    task automatic enter_phase(input int ph);
        t_mode            m;
        logic [DIM_W-1:0] ar;
        logic [DIM_W-1:0] ac;
        logic [DIM_W-1:0] br;
        logic [DIM_W-1:0] bc;
        m  = t_mode'($urandom_range(0, 3));
        ar = pick_dim();
        ac = pick_dim();
        br = pick_dim();
        bc = pick_dim();
        if ($urandom_range(0, 3) != 0) begin
            case (m)
                MODE_MUL: br = ac;
                MODE_ADD, MODE_SUB: begin
                    br = ar;
                    bc = ac;
                end
                default: ;
            endcase
        end
        if (ph == 0) {ar, ac, br, bc} = {4{5'd16}};
        if (ph == 1) {ar, ac, br, bc} = {4{5'd1}};
        set_config(m, ar, ac, br, bc);
    endtask

    task automatic send_random_beat(input bit narrow);
        t_req             rq;
        int               pick;
        int               nr;
        int               nc;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        logic [DATA_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 30) rq = REQ_LOAD_A;
        else if (pick < 55) rq = REQ_LOAD_B;
        else if (pick < 95) rq = REQ_READ;
        else rq = REQ_NONE;
        case (rq)
            REQ_LOAD_A: begin
                nr = clip_dim(cfg_a_rows);
                nc = clip_dim(cfg_a_cols);
            end
            REQ_LOAD_B: begin
                nr = clip_dim(cfg_b_rows);
                nc = clip_dim(cfg_b_cols);
            end
            REQ_READ: begin
                case (cfg_mode)
                    MODE_MUL: begin
                        nr = clip_dim(cfg_a_rows);
                        nc = clip_dim(cfg_b_cols);
                    end
                    MODE_TRN: begin
                        nr = clip_dim(cfg_a_cols);
                        nc = clip_dim(cfg_a_rows);
                    end
                    default: begin
                        nr = clip_dim(cfg_a_rows);
                        nc = clip_dim(cfg_a_cols);
                    end
                endcase
            end
            default: begin
                nr = MAX_DIM_DEF;
                nc = MAX_DIM_DEF;
            end
        endcase
        if (nr == 0 || nc == 0 || $urandom_range(0, 5) == 0) begin
            r = IDX_W'($urandom);
            c = IDX_W'($urandom);
        end else begin
            r = IDX_W'($urandom_range(0, nr - 1));
            c = IDX_W'($urandom_range(0, nc - 1));
        end
        case ($urandom_range(0, 19))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'hFFFF;
            3:       v = 16'h0000;
            default: v = narrow ? DATA_W'($urandom_range(0, 8191)) - 16'd4096 : DATA_W'($urandom);
        endcase
        send_beat(rq, r, c, v);
    endtask

    initial begin
        int order [0:511];
        int j;
        int tmp;
        bit narrow;
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        start      <= 1'b0;
        i_req_type <= REQ_NONE;
        i_row      <= '0;
        i_col      <= '0;
        i_value    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(REQ_LOAD_A, 4'd15, 4'd15, 16'h7FFF);
        send_beat(REQ_LOAD_B, 4'd15, 4'd15, 16'h8000);
        send_beat(REQ_NONE, 4'd15, 4'd15, 16'hFFFF);

        set_config(MODE_MUL, 5'd1, 5'd1, 5'd1, 5'd1);
        send_beat(REQ_LOAD_A, 4'd0, 4'd0, 16'h0001);
        send_beat(REQ_LOAD_B, 4'd0, 4'd0, 16'h0800);
        send_beat(REQ_READ, 4'd0, 4'd0, 16'h0000);
        send_beat(REQ_LOAD_A, 4'd0, 4'd0, 16'hFFFF);
        send_beat(REQ_READ, 4'd0, 4'd0, 16'hFFFF);
        send_beat(REQ_LOAD_A, 4'd1, 4'd0, 16'h1234);
        send_beat(REQ_LOAD_B, 4'd0, 4'd15, 16'h4321);
        send_beat(REQ_READ, 4'd0, 4'd1, 16'h0000);
        send_beat(REQ_LOAD_A, 4'd0, 4'd0, 16'h7FFF);
        send_beat(REQ_LOAD_B, 4'd0, 4'd0, 16'h8000);
        send_beat(REQ_READ, 4'd0, 4'd0, 16'h0000);

        set_config(MODE_ADD, 5'd1, 5'd1, 5'd1, 5'd1);
        send_beat(REQ_READ, 4'd0, 4'd0, 16'h0000);
        set_config(MODE_SUB, 5'd1, 5'd1, 5'd1, 5'd1);
        send_beat(REQ_READ, 4'd0, 4'd0, 16'h0000);
        send_beat(REQ_LOAD_B, 4'd0, 4'd0, 16'h7FFF);
        send_beat(REQ_READ, 4'd0, 4'd0, 16'h0000);
        set_config(MODE_TRN, 5'd1, 5'd1, 5'd1, 5'd1);
        send_beat(REQ_READ, 4'd0, 4'd0, 16'h0000);
        send_beat(REQ_READ, 4'd1, 4'd0, 16'h0000);
        set_config(MODE_MUL, 5'd1, 5'd1, 5'd2, 5'd1);
        send_beat(REQ_READ, 4'd0, 4'd0, 16'h0000);
        set_config(MODE_ADD, 5'd1, 5'd1, 5'd1, 5'd2);
        send_beat(REQ_READ, 4'd0, 4'd0, 16'h0000);
        set_config(MODE_TRN, 5'd0, 5'd0, 5'd0, 5'd0);
        send_beat(REQ_LOAD_A, 4'd0, 4'd0, 16'h5555);
        send_beat(REQ_READ, 4'd0, 4'd0, 16'h0000);

        // fill both stores completely before any random read
        set_config(MODE_MUL, 5'd16, 5'd16, 5'd16, 5'd16);
        write_reg(REG_SPARE, PDATA_W'($urandom));
        for (int i = 0; i < 512; i++) order[i] = i;
        for (int i = 511; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) begin
            send_beat((order[i] < 256) ? REQ_LOAD_A : REQ_LOAD_B, IDX_W'(order[i] >> 4),
                      IDX_W'(order[i]), fill_value());
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            enter_phase(ph);
            narrow = $urandom_range(0, 1);
            repeat (PHASE_BEATS) send_random_beat(narrow);
        end
        settle();

        if (mismatches == 0) begin
            $display("** matrix_arithmetic_engine: PASSED **");
        end else begin
            $display("** matrix_arithmetic_engine: FAILED **");
        end
        $finish;
    end

endmodule
